// ----- src/complex_arithmetic_unit_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the complex arithmetic unit
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CAU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes, control bundle, arctangent table and saturation helper
// for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_POLAR = 3'd4
    } op_t;

    localparam int CORDIC_STEPS = 24;
    localparam int ANG_BITS     = 20;
    localparam int NORM_STAGES  = 6;
    localparam int NORM_TOP     = 40;
    localparam int XW           = 45;
    localparam int ZW           = 28;
    localparam int DEG_90       = 90;

    // atan(2^-i) in degrees with ANG_BITS fraction bits
    localparam logic signed [ZW-1:0] ATAN_DEG [CORDIC_STEPS] = '{
        28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
        28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
        28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
        28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
        28'sd917,      28'sd458,      28'sd229,      28'sd115,
        28'sd57,       28'sd29,       28'sd14,       28'sd7
    };

    typedef struct packed {
        op_t  op;
        logic re_zero;
        logic im_zero;
        logic im_neg;
        logic den_zero;
        logic dir_ovf;
        logic n1_neg;
        logic n2_neg;
        logic q1_sat;
        logic q2_sat;
    } cau_ctrl_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    // Sign and magnitude to a wb-bit two's complement word, clamped
    function automatic sat_t sat_pack(input logic neg, input logic [63:0] mag,
                                      input int unsigned wb);
        sat_t        r;
        logic [63:0] lim;
        logic [63:0] m;
        lim   = 64'd1 << (wb - 1);
        m     = mag;
        r.ovf = 1'b0;
        if (neg)
        begin
            if (m > lim)
            begin
                r.ovf = 1'b1;
                m     = lim;
            end
            r.val = 32'(64'd0 - m);
        end
        else
        begin
            if (m > lim - 64'd1)
            begin
                r.ovf = 1'b1;
                m     = lim - 64'd1;
            end
            r.val = 32'(m);
        end
        return r;
    endfunction

endpackage

// ----- src/cau_front.sv -----
// ----------------------------------------------------------------------------
// cau_front
// Three-stage operand front end: partial products, sums, then direct
// add/subtract/multiply results and the seeds of the divide, root and
// angle lanes.
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [2:0]               kind,
    input  logic signed [W-1:0]      a_real,
    input  logic signed [W-1:0]      a_imag,
    input  logic signed [W-1:0]      b_real,
    input  logic signed [W-1:0]      b_imag,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output cau_ctrl_t                ctrl,
    output logic [W-1:0]             dir_first,
    output logic [W-1:0]             dir_second,
    output logic [2*W+F:0]           r1,
    output logic [2*W+F:0]           r2,
    output logic [2*W-1:0]           den,
    output logic [2*W-1:0]           srem,
    output logic signed [XW-1:0]     x,
    output logic signed [XW-1:0]     y
);

    localparam int PW = 2 * W;
    localparam int RW = 2 * W + F + 1;

    logic va_reg, vb_reg, vc_reg;
    logic rdy_a, rdy_b, rdy_c;

    // stage A
    op_t                 op_a_reg;
    logic                re_zero_a_reg, im_zero_a_reg, im_neg_a_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] sq_ar_reg, sq_ai_reg, sq_br_reg, sq_bi_reg;
    logic signed [W:0]   sum_r_a_reg, sum_i_a_reg, cx_a_reg, cy_a_reg;
    logic signed [W:0]   sum_r_next, sum_i_next, cx_next, cy_next;
    logic signed [W:0]   ar_ext, ai_ext;
    op_t                 op_in;

    // stage B
    op_t                 op_b_reg;
    logic                re_zero_b_reg, im_zero_b_reg, im_neg_b_reg;
    logic signed [PW:0]  mr_reg, mi_reg, n1_reg, n2_reg;
    logic [PW-1:0]       den_b_reg, s_b_reg;
    logic signed [W:0]   sum_r_b_reg, sum_i_b_reg, cx_b_reg, cy_b_reg;
    logic signed [PW:0]  den_full, s_full;

    // stage C
    cau_ctrl_t           ctrl_reg, ctrl_next;
    logic [W-1:0]        dir_first_reg, dir_second_reg, dir_first_next, dir_second_next;
    logic [RW-1:0]       r1_reg, r2_reg;
    logic [PW-1:0]       den_reg, srem_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic [W:0]          mag_sr, mag_si;
    logic [PW:0]         mag_mr, mag_mi, rnd_mr, rnd_mi, mag_n1, mag_n2;
    sat_t                pf, ps;

    assign rdy_c    = !vc_reg || dn_ready;
    assign rdy_b    = !vb_reg || rdy_c;
    assign rdy_a    = !va_reg || rdy_b;
    assign up_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= up_valid;
            if (rdy_b)
                vb_reg <= va_reg;
            if (rdy_c)
                vc_reg <= vb_reg;
        end
    end

    always_comb
    begin
        op_in      = op_t'(kind);
        ar_ext     = {a_real[W-1], a_real};
        ai_ext     = {a_imag[W-1], a_imag};
        sum_r_next = (op_in == OP_SUB) ? a_real - b_real : a_real + b_real;
        sum_i_next = (op_in == OP_SUB) ? a_imag - b_imag : a_imag + b_imag;
        // fold into the right half plane
        cx_next    = a_real[W-1] ? -ar_ext : ar_ext;
        cy_next    = a_real[W-1] ? -ai_ext : ai_ext;
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && up_valid)
        begin
            op_a_reg      <= op_in;
            re_zero_a_reg <= (a_real == '0);
            im_zero_a_reg <= (a_imag == '0);
            im_neg_a_reg  <= a_imag[W-1];
            p_rr_reg      <= a_real * b_real;
            p_ii_reg      <= a_imag * b_imag;
            p_ri_reg      <= a_real * b_imag;
            p_ir_reg      <= a_imag * b_real;
            sq_ar_reg     <= a_real * a_real;
            sq_ai_reg     <= a_imag * a_imag;
            sq_br_reg     <= b_real * b_real;
            sq_bi_reg     <= b_imag * b_imag;
            sum_r_a_reg   <= sum_r_next;
            sum_i_a_reg   <= sum_i_next;
            cx_a_reg      <= cx_next;
            cy_a_reg      <= cy_next;
        end
    end

    assign den_full = sq_br_reg + sq_bi_reg;
    assign s_full   = sq_ar_reg + sq_ai_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_b && va_reg)
        begin
            op_b_reg      <= op_a_reg;
            re_zero_b_reg <= re_zero_a_reg;
            im_zero_b_reg <= im_zero_a_reg;
            im_neg_b_reg  <= im_neg_a_reg;
            mr_reg        <= p_rr_reg - p_ii_reg;
            mi_reg        <= p_ri_reg + p_ir_reg;
            n1_reg        <= p_rr_reg + p_ii_reg;
            n2_reg        <= p_ir_reg - p_ri_reg;
            den_b_reg     <= den_full[PW-1:0];
            s_b_reg       <= s_full[PW-1:0];
            sum_r_b_reg   <= sum_r_a_reg;
            sum_i_b_reg   <= sum_i_a_reg;
            cx_b_reg      <= cx_a_reg;
            cy_b_reg      <= cy_a_reg;
        end
    end

    always_comb
    begin
        mag_sr = sum_r_b_reg[W] ? (W+1)'(-sum_r_b_reg) : (W+1)'(sum_r_b_reg);
        mag_si = sum_i_b_reg[W] ? (W+1)'(-sum_i_b_reg) : (W+1)'(sum_i_b_reg);
        mag_mr = mr_reg[PW] ? (PW+1)'(-mr_reg) : (PW+1)'(mr_reg);
        mag_mi = mi_reg[PW] ? (PW+1)'(-mi_reg) : (PW+1)'(mi_reg);
        // round half away from zero on the magnitude
        rnd_mr = (mag_mr + ((PW+1)'(1) << (F - 1))) >> F;
        rnd_mi = (mag_mi + ((PW+1)'(1) << (F - 1))) >> F;
        mag_n1 = n1_reg[PW] ? (PW+1)'(-n1_reg) : (PW+1)'(n1_reg);
        mag_n2 = n2_reg[PW] ? (PW+1)'(-n2_reg) : (PW+1)'(n2_reg);

        pf = '0;
        ps = '0;
        unique case (op_b_reg)
            OP_ADD, OP_SUB:
            begin
                pf = sat_pack(sum_r_b_reg[W], 64'(mag_sr), W);
                ps = sat_pack(sum_i_b_reg[W], 64'(mag_si), W);
            end
            OP_MUL:
            begin
                pf = sat_pack(mr_reg[PW], 64'(rnd_mr), W);
                ps = sat_pack(mi_reg[PW], 64'(rnd_mi), W);
            end
            default:
            begin
                pf = '0;
                ps = '0;
            end
        endcase
        dir_first_next  = pf.val[W-1:0];
        dir_second_next = ps.val[W-1:0];

        ctrl_next          = '0;
        ctrl_next.op       = op_b_reg;
        ctrl_next.re_zero  = re_zero_b_reg;
        ctrl_next.im_zero  = im_zero_b_reg;
        ctrl_next.im_neg   = im_neg_b_reg;
        ctrl_next.den_zero = (den_b_reg == '0);
        ctrl_next.dir_ovf  = pf.ovf | ps.ovf;
        ctrl_next.n1_neg   = n1_reg[PW];
        ctrl_next.n2_neg   = n2_reg[PW];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && vb_reg)
        begin
            ctrl_reg       <= ctrl_next;
            dir_first_reg  <= dir_first_next;
            dir_second_reg <= dir_second_next;
            r1_reg         <= {mag_n1[PW-1:0], (F+1)'(0)};
            r2_reg         <= {mag_n2[PW-1:0], (F+1)'(0)};
            den_reg        <= den_b_reg;
            srem_reg       <= s_b_reg;
            x_reg          <= XW'(cx_b_reg);
            y_reg          <= XW'(cy_b_reg);
        end
    end

    assign dn_valid   = vc_reg;
    assign ctrl       = ctrl_reg;
    assign dir_first  = dir_first_reg;
    assign dir_second = dir_second_reg;
    assign r1         = r1_reg;
    assign r2         = r2_reg;
    assign den        = den_reg;
    assign srem       = srem_reg;
    assign x          = x_reg;
    assign y          = y_reg;

endmodule

// ----- src/cau_cell.sv -----
// ----------------------------------------------------------------------------
// cau_cell
// One link of the processing chain. By its position it performs one
// restoring quotient bit on both divide lanes (the first cell checks the
// quotient range instead), one root bit, and one normalization shift or one
// CORDIC rotation; lanes outside its range pass through.
// ----------------------------------------------------------------------------
module cau_cell import cau_pkg::*; #(
    parameter int W   = 16,
    parameter int F   = 8,
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  cau_ctrl_t             up_ctrl,
    input  logic [W-1:0]          up_dir_first,
    input  logic [W-1:0]          up_dir_second,
    input  logic [2*W+F:0]        up_r1,
    input  logic [2*W+F:0]        up_r2,
    input  logic [W:0]            up_q1,
    input  logic [W:0]            up_q2,
    input  logic [2*W-1:0]        up_den,
    input  logic [2*W-1:0]        up_srem,
    input  logic [W-1:0]          up_root,
    input  logic signed [XW-1:0]  up_x,
    input  logic signed [XW-1:0]  up_y,
    input  logic signed [ZW-1:0]  up_z,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output cau_ctrl_t             ctrl,
    output logic [W-1:0]          dir_first,
    output logic [W-1:0]          dir_second,
    output logic [2*W+F:0]        r1,
    output logic [2*W+F:0]        r2,
    output logic [W:0]            q1,
    output logic [W:0]            q2,
    output logic [2*W-1:0]        den,
    output logic [2*W-1:0]        srem,
    output logic [W-1:0]          root,
    output logic signed [XW-1:0]  x,
    output logic signed [XW-1:0]  y,
    output logic signed [ZW-1:0]  z
);

    localparam int RW       = 2 * W + F + 1;
    localparam int CW       = (3 * W + 2 > RW) ? 3 * W + 2 : RW;
    localparam int SQW      = 2 * W + 1;
    localparam bit DIV_SAT  = (IDX == 0);
    localparam bit DIV_STEP = (IDX >= 1) && (IDX <= W + 1);
    localparam int DIV_K    = DIV_STEP ? (W + 1 - IDX) : 0;
    localparam bit SQ_STEP  = (IDX < W);
    localparam int SQ_K     = SQ_STEP ? (W - 1 - IDX) : 0;
    localparam bit NORM     = (IDX < NORM_STAGES);
    localparam int NORM_SH  = NORM ? (1 << (NORM_STAGES - 1 - IDX)) : 0;
    localparam int NORM_LIM = NORM_TOP + 1 - NORM_SH;
    localparam bit ROT      = (IDX >= NORM_STAGES) && (IDX < NORM_STAGES + CORDIC_STEPS);
    localparam int ROT_I    = ROT ? (IDX - NORM_STAGES) : 0;

    logic                 v_reg, rdy;
    cau_ctrl_t            ctrl_reg, ctrl_next;
    logic [W-1:0]         dir_first_reg, dir_second_reg;
    logic [RW-1:0]        r1_reg, r2_reg, r1_next, r2_next;
    logic [W:0]           q1_reg, q2_reg, q1_next, q2_next;
    logic [2*W-1:0]       den_reg, srem_reg, srem_next;
    logic [W-1:0]         root_reg, root_next;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic [CW-1:0]        den_ext, r1_ext, r2_ext, dsh;
    logic [SQW-1:0]       sq_t, srem_ext;
    logic signed [XW-1:0] ay, mx, dx, dy;

    assign rdy      = !v_reg || dn_ready;
    assign up_ready = rdy;

    always_comb
    begin
        ctrl_next = up_ctrl;
        r1_next   = up_r1;
        r2_next   = up_r2;
        q1_next   = up_q1;
        q2_next   = up_q2;
        srem_next = up_srem;
        root_next = up_root;
        x_next    = up_x;
        y_next    = up_y;
        z_next    = up_z;

        den_ext  = CW'(up_den);
        r1_ext   = CW'(up_r1);
        r2_ext   = CW'(up_r2);
        dsh      = den_ext << DIV_K;
        sq_t     = (SQW'(up_root) << (SQ_K + 1)) + (SQW'(1) << (2 * SQ_K));
        srem_ext = SQW'(up_srem);
        ay       = up_y[XW-1] ? -up_y : up_y;
        mx       = (up_x > ay) ? up_x : ay;
        dx       = up_y >>> ROT_I;
        dy       = up_x >>> ROT_I;

        // quotient too large for the word: flag and let the bits run free
        if (DIV_SAT)
        begin
            ctrl_next.q1_sat = (r1_ext >= (den_ext << (W + 1)));
            ctrl_next.q2_sat = (r2_ext >= (den_ext << (W + 1)));
        end

        if (DIV_STEP)
        begin
            if (r1_ext >= dsh)
            begin
                r1_next = RW'(r1_ext - dsh);
                q1_next = {up_q1[W-1:0], 1'b1};
            end
            else
            begin
                q1_next = {up_q1[W-1:0], 1'b0};
            end
            if (r2_ext >= dsh)
            begin
                r2_next = RW'(r2_ext - dsh);
                q2_next = {up_q2[W-1:0], 1'b1};
            end
            else
            begin
                q2_next = {up_q2[W-1:0], 1'b0};
            end
        end

        if (SQ_STEP)
        begin
            if (srem_ext >= sq_t)
            begin
                srem_next = (2*W)'(srem_ext - sq_t);
                root_next = up_root | (W'(1) << SQ_K);
            end
        end

        // binary search for the shift that brings the larger part to the top
        if (NORM)
        begin
            if (mx < (XW'(1) << NORM_LIM))
            begin
                x_next = up_x <<< NORM_SH;
                y_next = up_y <<< NORM_SH;
            end
        end

        if (ROT)
        begin
            if (up_y > 0)
            begin
                x_next = up_x + dx;
                y_next = up_y - dy;
                z_next = up_z + ATAN_DEG[ROT_I];
            end
            else
            begin
                x_next = up_x - dx;
                y_next = up_y + dy;
                z_next = up_z - ATAN_DEG[ROT_I];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (rdy)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            ctrl_reg       <= ctrl_next;
            dir_first_reg  <= up_dir_first;
            dir_second_reg <= up_dir_second;
            r1_reg         <= r1_next;
            r2_reg         <= r2_next;
            q1_reg         <= q1_next;
            q2_reg         <= q2_next;
            den_reg        <= up_den;
            srem_reg       <= srem_next;
            root_reg       <= root_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
        end
    end

    assign dn_valid   = v_reg;
    assign ctrl       = ctrl_reg;
    assign dir_first  = dir_first_reg;
    assign dir_second = dir_second_reg;
    assign r1         = r1_reg;
    assign r2         = r2_reg;
    assign q1         = q1_reg;
    assign q2         = q2_reg;
    assign den        = den_reg;
    assign srem       = srem_reg;
    assign root       = root_reg;
    assign x          = x_reg;
    assign y          = y_reg;
    assign z          = z_reg;

endmodule

// ----- src/cau_back.sv -----
// ----------------------------------------------------------------------------
// cau_back
// Result stage: rounds quotients, root and angle, applies the polar
// special cases, selects by operation and holds the result register.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_defines.svh"

module cau_back import cau_pkg::*; #(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  cau_ctrl_t             ctrl,
    input  logic [W-1:0]          dir_first,
    input  logic [W-1:0]          dir_second,
    input  logic [W:0]            q1,
    input  logic [W:0]            q2,
    input  logic [2*W-1:0]        srem,
    input  logic [W-1:0]          root,
    input  logic signed [ZW-1:0]  z,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [W-1:0]          res_first,
    output logic [W-1:0]          res_second,
    output logic                  overflow,
    output logic                  div_zero
);

    localparam int ASH = ANG_BITS - F;

    logic         rv_reg, rdy;
    logic [W-1:0] first_reg, second_reg, first_next, second_next;
    logic         ovf_reg, dz_reg, ovf_next, dz_next;

    logic [W+1:0]   qr1, qr2;
    logic [W:0]     rt;
    logic [ZW-1:0]  zmag, amag, lim90;
    logic           aneg;
    sat_t           p1, p2, pm, pa;

    assign rdy      = !rv_reg || !result_stall;
    assign up_ready = rdy;

    always_comb
    begin
        // halve the quotient with one guard bit: round half away from zero
        qr1 = ((W+2)'(q1) + (W+2)'(1)) >> 1;
        qr2 = ((W+2)'(q2) + (W+2)'(1)) >> 1;
        p1  = sat_pack(ctrl.n1_neg, ctrl.q1_sat ? (64'd1 << W) : 64'(qr1), W);
        p2  = sat_pack(ctrl.n2_neg, ctrl.q2_sat ? (64'd1 << W) : 64'(qr2), W);

        rt  = (W+1)'(root) + (W+1)'(srem > (2*W)'(root));
        pm  = sat_pack(1'b0, 64'(rt), W);

        lim90 = ZW'(DEG_90) << F;
        zmag  = z[ZW-1] ? ZW'(-z) : ZW'(z);
        amag  = (zmag + (ZW'(1) << (ASH - 1))) >> ASH;
        aneg  = z[ZW-1];
        if (amag > lim90)
            amag = lim90;
        priority if (ctrl.im_zero)
        begin
            amag = '0;
            aneg = 1'b0;
        end
        else if (ctrl.re_zero)
        begin
            amag = lim90;
            aneg = ctrl.im_neg;
        end
        pa = sat_pack(aneg, 64'(amag), W);

        first_next  = '0;
        second_next = '0;
        ovf_next    = 1'b0;
        dz_next     = 1'b0;
        unique case (ctrl.op)
            OP_ADD, OP_SUB, OP_MUL:
            begin
                first_next  = dir_first;
                second_next = dir_second;
                ovf_next    = ctrl.dir_ovf;
            end
            OP_DIV:
            begin
                if (ctrl.den_zero)
                begin
                    dz_next = 1'b1;
                end
                else
                begin
                    first_next  = p1.val[W-1:0];
                    second_next = p2.val[W-1:0];
                    ovf_next    = p1.ovf | p2.ovf;
                end
            end
            OP_POLAR:
            begin
                first_next  = pm.val[W-1:0];
                second_next = pa.val[W-1:0];
                ovf_next    = pm.ovf | pa.ovf;
            end
            default:
            begin
                first_next  = '0;
                second_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (rdy)
            rv_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            ovf_reg    <= ovf_next;
            dz_reg     <= dz_next;
        end
    end

    assign result_valid = rv_reg;
    assign res_first    = first_reg;
    assign res_second   = second_reg;
    assign overflow     = ovf_reg;
    assign div_zero     = dz_reg;

    `CAU_ASSERT_SAME(a_dz_clean, clk, rst_n, result_valid && div_zero, !overflow && res_first == '0 && res_second == '0, "zero divisor result not cleared")
    `CAU_ASSERT_NEXT(a_dz_raise, clk, rst_n, up_valid && rdy && ctrl.op == OP_DIV && ctrl.den_zero, result_valid && div_zero, "zero divisor not flagged")
    `CAU_ASSERT_NEXT(a_mag_pos, clk, rst_n, up_valid && rdy && ctrl.op == OP_POLAR, result_valid && !res_first[W-1], "polar magnitude negative")

endmodule

// ----- src/complex_arithmetic_unit_top.sv -----
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex ALU on signed fixed-point parts: add, subtract,
// multiply, divide and polar conversion of the first operand.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  item      item_valid / item_stall     kind, a_real, a_imag, b_real, b_imag
//  result    result_valid / result_stall res_first, res_second, overflow, div_zero
//
//  One transaction per cycle sustained while result_stall is low; all operations
//  take the same path: 3 front stages + N_CELLS chain cells + 1 result register.
//  N_CELLS is the longer of the divider (one quotient bit per cell plus a range
//  check) and the angle path (6 normalization shifts + 24 CORDIC rotations).
//  Each stage holds its transaction while the one after it is full and stalled;
//  empty stages still fill, so item_stall rises only when the whole chain is full.
//  Reset clears the valid bits only; no clearing pass.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top import cau_pkg::*; #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [2:0]                  kind,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [WORD_BITS-1:0] res_first,
    output logic signed [WORD_BITS-1:0] res_second,
    output logic                        overflow,
    output logic                        div_zero
);

    localparam int W       = WORD_BITS;
    localparam int F       = FRAC_BITS;
    localparam int RW      = 2 * W + F + 1;
    localparam int N_CELLS = (W + 2 > NORM_STAGES + CORDIC_STEPS) ?
                             W + 2 : NORM_STAGES + CORDIC_STEPS;

    logic                 v_w     [N_CELLS+1];
    logic                 rdy_w   [N_CELLS+1];
    cau_ctrl_t            ctrl_w  [N_CELLS+1];
    logic [W-1:0]         df_w    [N_CELLS+1];
    logic [W-1:0]         ds_w    [N_CELLS+1];
    logic [RW-1:0]        r1_w    [N_CELLS+1];
    logic [RW-1:0]        r2_w    [N_CELLS+1];
    logic [W:0]           q1_w    [N_CELLS+1];
    logic [W:0]           q2_w    [N_CELLS+1];
    logic [2*W-1:0]       den_w   [N_CELLS+1];
    logic [2*W-1:0]       srem_w  [N_CELLS+1];
    logic [W-1:0]         root_w  [N_CELLS+1];
    logic signed [XW-1:0] x_w     [N_CELLS+1];
    logic signed [XW-1:0] y_w     [N_CELLS+1];
    logic signed [ZW-1:0] z_w     [N_CELLS+1];
    logic                 front_ready;
    logic [W-1:0]         first_q, second_q;

    cau_front #(.W(W), .F(F)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (item_valid),
        .up_ready   (front_ready),
        .kind       (kind),
        .a_real     (a_real),
        .a_imag     (a_imag),
        .b_real     (b_real),
        .b_imag     (b_imag),
        .dn_valid   (v_w[0]),
        .dn_ready   (rdy_w[0]),
        .ctrl       (ctrl_w[0]),
        .dir_first  (df_w[0]),
        .dir_second (ds_w[0]),
        .r1         (r1_w[0]),
        .r2         (r2_w[0]),
        .den        (den_w[0]),
        .srem       (srem_w[0]),
        .x          (x_w[0]),
        .y          (y_w[0])
    );

    assign item_stall = !front_ready;
    assign q1_w[0]    = '0;
    assign q2_w[0]    = '0;
    assign root_w[0]  = '0;
    assign z_w[0]     = '0;

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        cau_cell #(.W(W), .F(F), .IDX(i)) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .up_valid      (v_w[i]),
            .up_ready      (rdy_w[i]),
            .up_ctrl       (ctrl_w[i]),
            .up_dir_first  (df_w[i]),
            .up_dir_second (ds_w[i]),
            .up_r1         (r1_w[i]),
            .up_r2         (r2_w[i]),
            .up_q1         (q1_w[i]),
            .up_q2         (q2_w[i]),
            .up_den        (den_w[i]),
            .up_srem       (srem_w[i]),
            .up_root       (root_w[i]),
            .up_x          (x_w[i]),
            .up_y          (y_w[i]),
            .up_z          (z_w[i]),
            .dn_valid      (v_w[i+1]),
            .dn_ready      (rdy_w[i+1]),
            .ctrl          (ctrl_w[i+1]),
            .dir_first     (df_w[i+1]),
            .dir_second    (ds_w[i+1]),
            .r1            (r1_w[i+1]),
            .r2            (r2_w[i+1]),
            .q1            (q1_w[i+1]),
            .q2            (q2_w[i+1]),
            .den           (den_w[i+1]),
            .srem          (srem_w[i+1]),
            .root          (root_w[i+1]),
            .x             (x_w[i+1]),
            .y             (y_w[i+1]),
            .z             (z_w[i+1])
        );
    end

    // division remainders, divisor and rotated vector of the last cell are not needed
    cau_back #(.W(W), .F(F)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .up_valid     (v_w[N_CELLS]),
        .up_ready     (rdy_w[N_CELLS]),
        .ctrl         (ctrl_w[N_CELLS]),
        .dir_first    (df_w[N_CELLS]),
        .dir_second   (ds_w[N_CELLS]),
        .q1           (q1_w[N_CELLS]),
        .q2           (q2_w[N_CELLS]),
        .srem         (srem_w[N_CELLS]),
        .root         (root_w[N_CELLS]),
        .z            (z_w[N_CELLS]),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res_first    (first_q),
        .res_second   (second_q),
        .overflow     (overflow),
        .div_zero     (div_zero)
    );

    assign res_first  = first_q;
    assign res_second = second_q;

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives directed and random operand transactions with random idle and stall
// cycles. Each result is checked field by field against the value set in its
// row or a predictor of fixed-point add, sub, mul, div and polar results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import cau_pkg::*;

    localparam int          FRAC_BITS   = 8;
    localparam int          WORD_BITS   = 16;
    localparam int          LATENCY     = 34;
    localparam int          N_RANDOM    = 750;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  KIND_SPARE  = 3'd7;

    typedef struct {
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic               ovf;
        logic               dz;
    } cplx_result_t;

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] ar;
        logic signed [15:0] ai;
        logic signed [15:0] br;
        logic signed [15:0] bi;
        bit                 typed;
        cplx_result_t       want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        item_valid;
    logic                        item_stall;
    logic [2:0]                  kind;
    logic signed [WORD_BITS-1:0] a_real;
    logic signed [WORD_BITS-1:0] a_imag;
    logic signed [WORD_BITS-1:0] b_real;
    logic signed [WORD_BITS-1:0] b_imag;
    logic                        result_valid;
    logic                        result_stall;
    logic signed [WORD_BITS-1:0] res_first;
    logic signed [WORD_BITS-1:0] res_second;
    logic                        overflow;
    logic                        div_zero;

    cplx_result_t pending_results[$];
    int           mismatches = 0;
    int           cycles = 0;
    bit           quiet;

    complex_arithmetic_unit_top #(
        .FRAC_BITS(FRAC_BITS),
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .kind(kind),
        .a_real(a_real),
        .a_imag(a_imag),
        .b_real(b_real),
        .b_imag(b_imag),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .res_first(res_first),
        .res_second(res_second),
        .overflow(overflow),
        .div_zero(div_zero)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sign and magnitude to a saturated word
    function automatic logic [15:0] clamp_word(input bit neg, input longint unsigned mag,
                                               inout logic ovf);
        longint unsigned lim;
        lim = 64'd1 << (WORD_BITS - 1);
        if (neg)
        begin
            if (mag > lim)
            begin
                ovf = 1'b1;
                mag = lim;
            end
            return 16'(64'd0 - mag);
        end
        if (mag > lim - 1)
        begin
            ovf = 1'b1;
            mag = lim - 1;
        end
        return 16'(mag);
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned div_round(input longint unsigned num,
                                                  input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q >= (64'd1 << WORD_BITS))
            return 64'd1 << WORD_BITS;
        for (int i = 0; i < FRAC_BITS + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    function automatic longint unsigned sqrt_round(input longint unsigned s);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        rem  = s;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        if (s - root * root > root)
            root++;
        return root;
    endfunction

    // CORDIC vectoring angle in degrees, FRAC_BITS fraction bits, sign in neg
    function automatic longint unsigned angle_mag(input longint re, input longint im,
                                                  output bit neg);
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned m;
        longint unsigned lim;
        lim = longint'(DEG_90) << FRAC_BITS;
        neg = 1'b0;
        if (im == 0)
            return 0;
        if (re == 0)
        begin
            neg = im < 0;
            return lim;
        end
        x = (re < 0) ? -re : re;
        y = (re < 0) ? -im : im;
        z = 0;
        m = (abs64(y) > x) ? abs64(y) : x;
        while (m < (64'd1 << NORM_TOP))
        begin
            m = m << 1;
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_DEG[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_DEG[i]);
            end
        end
        neg = z < 0;
        m   = abs64(z);
        m   = (m + (64'd1 << (ANG_BITS - FRAC_BITS - 1))) >> (ANG_BITS - FRAC_BITS);
        if (m > lim)
            m = lim;
        if (m == 0)
            neg = 1'b0;
        return m;
    endfunction

    function automatic cplx_result_t compute_result(input logic [2:0] op,
                                                    input longint ar, input longint ai,
                                                    input longint br, input longint bi);
        cplx_result_t    res;
        longint          n1;
        longint          n2;
        longint unsigned den;
        longint unsigned m;
        bit              ang_neg;
        res = '{first: '0, second: '0, ovf: 1'b0, dz: 1'b0};
        case (op)
            OP_ADD:
            begin
                res.first  = clamp_word(ar + br < 0, abs64(ar + br), res.ovf);
                res.second = clamp_word(ai + bi < 0, abs64(ai + bi), res.ovf);
            end
            OP_SUB:
            begin
                res.first  = clamp_word(ar - br < 0, abs64(ar - br), res.ovf);
                res.second = clamp_word(ai - bi < 0, abs64(ai - bi), res.ovf);
            end
            OP_MUL:
            begin
                n1 = ar * br - ai * bi;
                n2 = ar * bi + ai * br;
                m  = (abs64(n1) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                res.first  = clamp_word(n1 < 0 && m != 0, m, res.ovf);
                m  = (abs64(n2) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                res.second = clamp_word(n2 < 0 && m != 0, m, res.ovf);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    res.dz = 1'b1;
                else
                begin
                    n1 = ar * br + ai * bi;
                    n2 = ai * br - ar * bi;
                    m  = div_round(abs64(n1), den);
                    res.first  = clamp_word(n1 < 0 && m != 0, m, res.ovf);
                    m  = div_round(abs64(n2), den);
                    res.second = clamp_word(n2 < 0 && m != 0, m, res.ovf);
                end
            end
            OP_POLAR:
            begin
                res.first  = clamp_word(1'b0, sqrt_round(ar * ar + ai * ai), res.ovf);
                m          = angle_mag(ar, ai, ang_neg);
                res.second = clamp_word(ang_neg, m, res.ovf);
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // hold the payload until the transaction is taken, then queue its result
    task automatic send_item(input stim_row_t row);
        while (!quiet && $urandom_range(0, 99) < 12)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= row.op;
        a_real     <= row.ar;
        a_imag     <= row.ai;
        b_real     <= row.br;
        b_imag     <= row.bi;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (row.typed)
            pending_results.push_back(row.want);
        else
            pending_results.push_back(compute_result(row.op, row.ar, row.ai,
                                                     row.br, row.bi));
    endtask

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 5))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'($signed($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        result_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 12);
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                // a result with no transaction behind it
                report_mismatch("result_valid", 16'd1, 16'd0);
            end
            else
            begin
                cplx_result_t want;
                want = pending_results.pop_front();
                if (res_first !== want.first)
                    report_mismatch("res_first", res_first, want.first);
                if (res_second !== want.second)
                    report_mismatch("res_second", res_second, want.second);
                if (overflow !== want.ovf)
                    report_mismatch("overflow", overflow, want.ovf);
                if (div_zero !== want.dz)
                    report_mismatch("div_zero", div_zero, want.dz);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    stim_row_t directed_rows[] = '{
        '{OP_ADD,   16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1,
          '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0}},
        '{OP_SUB,   16'sh8000, 16'sh0000, 16'sh7fff, 16'sh0000, 1'b1,
          '{16'sh8000, 16'sh0000, 1'b1, 1'b0}},
        '{OP_ADD,   16'sh0100, -16'sh0100, 16'sh0080, 16'sh0080, 1'b1,
          '{16'sh0180, -16'sh0080, 1'b0, 1'b0}},
        '{OP_MUL,   16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1'b1,
          '{16'sh0100, 16'sh0000, 1'b0, 1'b0}},
        '{OP_MUL,   16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000, 1'b1,
          '{16'sh7fff, 16'sh0000, 1'b1, 1'b0}},
        '{OP_MUL,   16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, '{0, 0, 0, 0}},
        '{OP_DIV,   16'sh1234, 16'sh4321, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0000, 16'sh0000, 1'b0, 1'b1}},
        '{OP_DIV,   16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1'b1,
          '{16'sh0100, 16'sh0000, 1'b0, 1'b0}},
        '{OP_DIV,   16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000, 1'b1,
          '{16'sh7fff, 16'sh7fff, 1'b1, 1'b0}},
        '{OP_DIV,   16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '{0, 0, 0, 0}},
        '{OP_POLAR, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 1'b1,
          '{16'sh0000, 16'sh0000, 1'b0, 1'b0}},
        '{OP_POLAR, 16'sh0000, 16'sh0100, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0100, 16'sh5a00, 1'b0, 1'b0}},
        '{OP_POLAR, 16'sh0000, -16'sh0100, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0100, -16'sh5a00, 1'b0, 1'b0}},
        '{OP_POLAR, -16'sh0300, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh0300, 16'sh0000, 1'b0, 1'b0}},
        '{OP_POLAR, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1,
          '{16'sh7fff, 16'sh2d00, 1'b1, 1'b0}},
        '{OP_POLAR, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000, 1'b0, '{0, 0, 0, 0}},
        '{OP_POLAR, -16'sh0100, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, '{0, 0, 0, 0}},
        '{KIND_SPARE, 16'sh7fff, 16'sh8000, 16'sh1111, 16'sh2222, 1'b1,
          '{16'sh0000, 16'sh0000, 1'b0, 1'b0}}
    };

    initial
    begin
        stim_row_t row;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        result_stall = 1'b0;
        kind         = '0;
        a_real       = '0;
        a_imag       = '0;
        b_real       = '0;
        b_imag       = '0;
        quiet        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // a long run with neither side idling
            quiet     = (n >= 300 && n < 450);
            row.op    = 3'($urandom_range(0, 9) > 8 ? $urandom_range(5, 7)
                                                    : $urandom_range(0, 4));
            row.ar    = rand_part();
            row.ai    = rand_part();
            row.br    = rand_part();
            row.bi    = rand_part();
            row.typed = 1'b0;
            send_item(row);
        end
        item_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
